>>> hw/rtl/edme_pkg.sv
package edme_pkg;

   localparam int PINGS_PER_GROUP = 5;

   localparam int ECHO_W  = 16;
   localparam int ALPHA_W = 9;
   localparam int CM_W    = 10;
   localparam int SCALE_W = 12;
   localparam int DIST_W  = 18;
   localparam int PROD_W  = 28;
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 16;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam int CNT_W = $clog2(PINGS_PER_GROUP + 1);
   localparam int IDX_W = (PINGS_PER_GROUP > 1) ? $clog2(PINGS_PER_GROUP) : 1;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(51);
   localparam logic [CM_W-1:0]    MIN_RESET   = CM_W'(2);
   localparam logic [CM_W-1:0]    MAX_RESET   = CM_W'(400);
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1135);
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(256);

   typedef enum logic [1:0] {
      REG_ALPHA = 2'd0,
      REG_MIN   = 2'd1,
      REG_MAX   = 2'd2,
      REG_SCALE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha_q8;
      logic [CM_W-1:0]    min_distance_cm;
      logic [CM_W-1:0]    max_distance_cm;
      logic [SCALE_W-1:0] cm_per_us_q16;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_INSERT,
      ST_COUNT,
      ST_MEDIAN,
      ST_MUL_NEW,
      ST_MUL_OLD,
      ST_SUM,
      ST_OUT
   } state_type;

endpackage

>>> hw/rtl/edme_csr.sv
module edme_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [edme_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [edme_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [edme_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output edme_pkg::cfg_type            cfg
);

   edme_pkg::cfg_type         cfg_ff;
   edme_pkg::cfg_type         cfg_in;
   edme_pkg::reg_index_type   reg_index;
   logic                      write_en;

   assign reg_index = edme_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            edme_pkg::REG_ALPHA: begin
               cfg_in.alpha_q8 = csr_pwdata[edme_pkg::ALPHA_W-1:0];
            end
            edme_pkg::REG_MIN: begin
               cfg_in.min_distance_cm = csr_pwdata[edme_pkg::CM_W-1:0];
            end
            edme_pkg::REG_MAX: begin
               cfg_in.max_distance_cm = csr_pwdata[edme_pkg::CM_W-1:0];
            end
            edme_pkg::REG_SCALE: begin
               cfg_in.cm_per_us_q16 = csr_pwdata[edme_pkg::SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         edme_pkg::REG_ALPHA: begin
            csr_prdata = edme_pkg::DATA_W'(cfg_ff.alpha_q8);
         end
         edme_pkg::REG_MIN: begin
            csr_prdata = edme_pkg::DATA_W'(cfg_ff.min_distance_cm);
         end
         edme_pkg::REG_MAX: begin
            csr_prdata = edme_pkg::DATA_W'(cfg_ff.max_distance_cm);
         end
         edme_pkg::REG_SCALE: begin
            csr_prdata = edme_pkg::DATA_W'(cfg_ff.cm_per_us_q16);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_q8        <= edme_pkg::ALPHA_RESET;
         cfg_ff.min_distance_cm <= edme_pkg::MIN_RESET;
         cfg_ff.max_distance_cm <= edme_pkg::MAX_RESET;
         cfg_ff.cm_per_us_q16   <= edme_pkg::SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/echo_distance_median_ema_core.sv
// Channel  Direction  Transfer when        Payload
// req      in         req_valid&req_ready  req_echo_us
// rsp      out        rsp_valid&rsp_ready  rsp_filtered_distance, rsp_no_valid
// csr      in/out     psel&penable&pwrite  csr_paddr, csr_pwdata, csr_prdata
//
// A timeout ping skips to the group count; others pass the multiplier and the window
// check, and a kept one is inserted into the sorted sample file, moving one entry per
// cycle. The last ping of a group with kept pings adds the median read and, unless the
// filter is zero, two passes through the shared 18x16 multiplier. Synchronous reset
// restores register defaults and clears the counts and the filter. req_ready is low
// while a ping is in work and while a finished group waits for a full output register.
module echo_distance_median_ema_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [edme_pkg::ECHO_W-1:0]         req_echo_us,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [edme_pkg::DIST_W-1:0]         rsp_filtered_distance,
   output logic                                rsp_no_valid,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [edme_pkg::ADDR_W-1:0]         csr_paddr,
   input  logic [edme_pkg::DATA_W-1:0]         csr_pwdata,
   output logic [edme_pkg::DATA_W-1:0]         csr_prdata,
   output logic                                csr_pready
);

   localparam int P     = edme_pkg::PINGS_PER_GROUP;
   localparam int CNT_W = edme_pkg::CNT_W;
   localparam int IDX_W = edme_pkg::IDX_W;
   localparam int DW    = edme_pkg::DIST_W;
   localparam int PW    = edme_pkg::PROD_W;

   edme_pkg::cfg_type     cfg;
   edme_pkg::state_type   state_ff, state_in;

   logic [edme_pkg::ECHO_W-1:0]  echo_ff, echo_in;
   logic [PW-1:0]                prod_ff, prod_in;
   logic [PW-1:0]                acc_ff, acc_in;
   logic [DW-1:0]                val_ff, val_in;
   logic [DW-1:0]                med_ff, med_in;
   logic [DW-1:0]                filt_ff, filt_in;
   logic [CNT_W-1:0]             kept_cnt_ff, kept_cnt_in;
   logic [CNT_W-1:0]             ping_cnt_ff, ping_cnt_in;
   logic [CNT_W-1:0]             pos_ff, pos_in;
   logic                         nv_ff, nv_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                rsp_dist_ff, rsp_dist_in;
   logic                         rsp_nv_ff, rsp_nv_in;

   logic [DW-1:0]                samples_ff [P];
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_idx;
   logic [DW-1:0]                wr_data;
   logic [IDX_W-1:0]             rd_idx;
   logic [DW-1:0]                rd_data;

   logic [edme_pkg::MUL_A_W-1:0] mul_a;
   logic [edme_pkg::MUL_B_W-1:0] mul_b;
   logic [edme_pkg::MUL_A_W+edme_pkg::MUL_B_W-1:0] mul_p;

   logic [edme_pkg::ALPHA_W-1:0] alpha_sat;
   logic [edme_pkg::ALPHA_W-1:0] alpha_inv;
   logic [PW-9:0]                range_q8;
   logic [PW-9:0]                lo_lim, hi_lim;
   logic [PW-1:0]                sum;
   logic                         out_free;

   edme_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign alpha_sat = (cfg.alpha_q8 > edme_pkg::ALPHA_ONE) ? edme_pkg::ALPHA_ONE
                                                            : cfg.alpha_q8;
   assign alpha_inv = edme_pkg::ALPHA_ONE - alpha_sat;

   assign range_q8 = prod_ff[PW-1:8];
   assign lo_lim   = (PW-8)'({cfg.min_distance_cm, 8'd0});
   assign hi_lim   = (PW-8)'({cfg.max_distance_cm, 8'd0});
   assign sum      = acc_ff + prod_ff;

   assign mul_p   = mul_a * mul_b;
   assign rd_data = samples_ff[rd_idx];

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready             = (state_ff == edme_pkg::ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_filtered_distance = rsp_dist_ff;
   assign rsp_no_valid          = rsp_nv_ff;

   always_comb begin
      state_in     = state_ff;
      echo_in      = echo_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      val_in       = val_ff;
      med_in       = med_ff;
      filt_in      = filt_ff;
      kept_cnt_in  = kept_cnt_ff;
      ping_cnt_in  = ping_cnt_ff;
      pos_in       = pos_ff;
      nv_in        = nv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_nv_in    = rsp_nv_ff;
      wr_en        = 1'b0;
      wr_idx       = IDX_W'(pos_ff);
      wr_data      = val_ff;
      rd_idx       = IDX_W'(pos_ff - CNT_W'(1));
      mul_a        = edme_pkg::MUL_A_W'(cfg.cm_per_us_q16);
      mul_b        = echo_ff;

      case (state_ff)
         edme_pkg::ST_IDLE: begin
            if (req_valid) begin
               echo_in  = req_echo_us;
               state_in = (req_echo_us == '0) ? edme_pkg::ST_COUNT : edme_pkg::ST_MUL;
            end
         end
         edme_pkg::ST_MUL: begin
            prod_in  = PW'(mul_p);
            state_in = edme_pkg::ST_CHECK;
         end
         edme_pkg::ST_CHECK: begin
            state_in = edme_pkg::ST_COUNT;
            if (range_q8 >= lo_lim && range_q8 <= hi_lim && kept_cnt_ff < CNT_W'(P)) begin
               val_in   = range_q8[DW-1:0];
               pos_in   = kept_cnt_ff;
               state_in = edme_pkg::ST_INSERT;
            end
         end
         edme_pkg::ST_INSERT: begin
            wr_en = 1'b1;
            if (pos_ff != '0 && rd_data > val_ff) begin
               wr_data = rd_data;
               pos_in  = pos_ff - CNT_W'(1);
            end else begin
               kept_cnt_in = kept_cnt_ff + CNT_W'(1);
               state_in    = edme_pkg::ST_COUNT;
            end
         end
         edme_pkg::ST_COUNT: begin
            if (ping_cnt_ff + CNT_W'(1) < CNT_W'(P)) begin
               ping_cnt_in = ping_cnt_ff + CNT_W'(1);
               state_in    = edme_pkg::ST_IDLE;
            end else begin
               nv_in    = (kept_cnt_ff == '0);
               state_in = (kept_cnt_ff == '0) ? edme_pkg::ST_OUT : edme_pkg::ST_MEDIAN;
            end
         end
         edme_pkg::ST_MEDIAN: begin
            rd_idx = IDX_W'(kept_cnt_ff >> 1);
            med_in = rd_data;
            if (filt_ff == '0) begin
               filt_in  = rd_data;
               state_in = edme_pkg::ST_OUT;
            end else begin
               state_in = edme_pkg::ST_MUL_NEW;
            end
         end
         edme_pkg::ST_MUL_NEW: begin
            mul_a    = med_ff;
            mul_b    = edme_pkg::MUL_B_W'(alpha_sat);
            prod_in  = PW'(mul_p);
            state_in = edme_pkg::ST_MUL_OLD;
         end
         edme_pkg::ST_MUL_OLD: begin
            mul_a    = filt_ff;
            mul_b    = edme_pkg::MUL_B_W'(alpha_inv);
            acc_in   = prod_ff + PW'(128);
            prod_in  = PW'(mul_p);
            state_in = edme_pkg::ST_SUM;
         end
         edme_pkg::ST_SUM: begin
            filt_in  = sum[DW+7:8];
            state_in = edme_pkg::ST_OUT;
         end
         edme_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = filt_ff;
               rsp_nv_in    = nv_ff;
               ping_cnt_in  = '0;
               kept_cnt_in  = '0;
               state_in     = edme_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = edme_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edme_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_cnt_ff  <= '0;
         ping_cnt_ff  <= '0;
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kept_cnt_ff  <= kept_cnt_in;
         ping_cnt_ff  <= ping_cnt_in;
         filt_ff      <= filt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      echo_ff     <= echo_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      val_ff      <= val_in;
      med_ff      <= med_in;
      pos_ff      <= pos_in;
      nv_ff       <= nv_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_nv_ff   <= rsp_nv_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         samples_ff[wr_idx] <= wr_data;
      end
   end

endmodule

>>> sim/tb_echo_distance_median_ema_core.sv
module tb_echo_distance_median_ema_core;

   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [edme_pkg::DIST_W-1:0] distance;
      logic                        no_valid;
   } range_reading_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [edme_pkg::ECHO_W-1:0]   req_echo_us;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [edme_pkg::DIST_W-1:0]   rsp_filtered_distance;
   logic                          rsp_no_valid;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [edme_pkg::ADDR_W-1:0]   csr_paddr;
   logic [edme_pkg::DATA_W-1:0]   csr_pwdata;
   logic [edme_pkg::DATA_W-1:0]   csr_prdata;
   logic                          csr_pready;

   // ping predictor state
   edme_pkg::cfg_type             ranger_cfg;
   logic [edme_pkg::DIST_W-1:0]   kept_dist [edme_pkg::PINGS_PER_GROUP];
   int                            kept_count;
   int                            pings_in_group;
   logic [edme_pkg::DIST_W-1:0]   ema_value;

   logic [edme_pkg::ECHO_W-1:0]   pending_echoes [$];
   range_reading_type             expected_readings [$];
   range_reading_type             head_reading;
   int                            pings_outstanding;
   int                            send_idle_pct;
   int                            recv_idle_pct;
   logic                          ping_xfer;
   int                            idle_cycles;
   int                            error_count;
   int                            pings_sent;
   int                            readings_checked;
   int                            settings_used;

   echo_distance_median_ema_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_echo_us           (req_echo_us),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_filtered_distance (rsp_filtered_distance),
      .rsp_no_valid          (rsp_no_valid),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic track_ping(input logic [edme_pkg::ECHO_W-1:0] echo);
      logic [edme_pkg::ECHO_W+edme_pkg::SCALE_W-1:0] prod;
      logic [edme_pkg::ECHO_W+edme_pkg::SCALE_W-9:0] dist_q8;
      logic [edme_pkg::DIST_W-1:0]  ordered [edme_pkg::PINGS_PER_GROUP];
      logic [edme_pkg::DIST_W-1:0]  v;
      logic [edme_pkg::DIST_W-1:0]  med;
      logic [edme_pkg::ALPHA_W-1:0] a;
      logic [35:0]                  blend;
      range_reading_type            r;
      int                           j;
      prod = echo * ranger_cfg.cm_per_us_q16;
      dist_q8 = prod >> 8;
      if (echo != 0 && dist_q8 >= {ranger_cfg.min_distance_cm, 8'd0} &&
          dist_q8 <= {ranger_cfg.max_distance_cm, 8'd0} &&
          kept_count < edme_pkg::PINGS_PER_GROUP) begin
         kept_dist[kept_count] = edme_pkg::DIST_W'(dist_q8);
         kept_count++;
      end
      pings_in_group++;
      if (pings_in_group < edme_pkg::PINGS_PER_GROUP) return;
      if (kept_count == 0) begin
         r.no_valid = 1'b1;
      end else begin
         for (int i = 0; i < kept_count; i++) ordered[i] = kept_dist[i];
         for (int i = 1; i < kept_count; i++) begin
            v = ordered[i];
            j = i;
            while (j > 0 && ordered[j-1] > v) begin
               ordered[j] = ordered[j-1];
               j--;
            end
            ordered[j] = v;
         end
         med = ordered[kept_count / 2];
         r.no_valid = 1'b0;
         if (ema_value == 0) begin
            ema_value = med;
         end else begin
            a = (ranger_cfg.alpha_q8 > 256) ? edme_pkg::ALPHA_W'(256) : ranger_cfg.alpha_q8;
            blend = 36'(a) * med + 36'(edme_pkg::ALPHA_W'(256) - a) * ema_value + 36'd128;
            ema_value = edme_pkg::DIST_W'(blend >> 8);
         end
      end
      r.distance = ema_value;
      expected_readings.push_back(r);
      pings_in_group = 0;
      kept_count = 0;
   endtask

   // driver: one transfer per valid, payload held until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || ping_xfer) begin
            if (pending_echoes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_echo_us <= pending_echoes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         ping_xfer   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         ping_xfer <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected transfer, distance %0d no_valid %0d",
                        $time, rsp_filtered_distance, rsp_no_valid);
               error_count++;
            end else begin
               head_reading = expected_readings.pop_front();
               readings_checked++;
               if (rsp_filtered_distance !== head_reading.distance) begin
                  $display("%0t: filtered_distance expected %0d got %0d",
                           $time, head_reading.distance, rsp_filtered_distance);
                  error_count++;
               end
               if (rsp_no_valid !== head_reading.no_valid) begin
                  $display("%0t: no_valid expected %0d got %0d",
                           $time, head_reading.no_valid, rsp_no_valid);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            track_ping(req_echo_us);
            pings_outstanding--;
            pings_sent++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic write_reg(input edme_pkg::reg_index_type idx,
                            input logic [edme_pkg::DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= edme_pkg::ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         edme_pkg::REG_ALPHA: ranger_cfg.alpha_q8        = value[edme_pkg::ALPHA_W-1:0];
         edme_pkg::REG_MIN:   ranger_cfg.min_distance_cm = value[edme_pkg::CM_W-1:0];
         edme_pkg::REG_MAX:   ranger_cfg.max_distance_cm = value[edme_pkg::CM_W-1:0];
         edme_pkg::REG_SCALE: ranger_cfg.cm_per_us_q16   = value[edme_pkg::SCALE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_ranger(input int alpha, input int min_cm, input int max_cm,
                                 input int scale);
      write_reg(edme_pkg::REG_ALPHA, edme_pkg::DATA_W'(alpha));
      write_reg(edme_pkg::REG_MIN, edme_pkg::DATA_W'(min_cm));
      write_reg(edme_pkg::REG_MAX, edme_pkg::DATA_W'(max_cm));
      write_reg(edme_pkg::REG_SCALE, edme_pkg::DATA_W'(scale));
      settings_used++;
   endtask

   // half the echoes land inside the window, some near its edges, the rest are random or zero
   function automatic logic [edme_pkg::ECHO_W-1:0] pick_echo();
      int unsigned sel;
      int unsigned lo;
      int unsigned hi;
      int unsigned target;
      int          e;
      sel = $urandom_range(99);
      if (sel < 10) return '0;
      if (sel < 35 || ranger_cfg.cm_per_us_q16 == 0 ||
          ranger_cfg.min_distance_cm > ranger_cfg.max_distance_cm)
         return edme_pkg::ECHO_W'($urandom);
      lo = ranger_cfg.min_distance_cm * 256;
      hi = ranger_cfg.max_distance_cm * 256;
      if (sel < 50) target = $urandom_range(1) ? hi : lo;
      else target = $urandom_range(hi, lo);
      e = (target * 256) / ranger_cfg.cm_per_us_q16 + int'($urandom_range(2)) - 1;
      if (e < 0) e = 0;
      if (e > 65535) e = 65535;
      return edme_pkg::ECHO_W'(e);
   endfunction

   task automatic wait_idle();
      do @(negedge clock); while (pings_outstanding != 0 || expected_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_echo(input logic [edme_pkg::ECHO_W-1:0] echo);
      pending_echoes.push_back(echo);
      pings_outstanding++;
   endtask

   task automatic run_batch(input int count, input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) queue_echo(pick_echo());
      wait_idle();
   endtask

   logic [edme_pkg::ECHO_W-1:0] directed_echoes [25] = '{
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
      16'd116, 16'd115, 16'd23096, 16'd23097, 16'hFFFF,
      16'd1, 16'd1000, 16'd2000, 16'd3000, 16'd4000,
      16'd5000, 16'd3000, 16'd0, 16'd4000, 16'd1000,
      16'h8000, 16'hFFFF, 16'd0, 16'h5555, 16'hAAAA
   };

   initial begin
      int min_cm;
      int max_cm;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_echo_us = '0;
      rsp_ready   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      ranger_cfg.alpha_q8        = 9'd51;
      ranger_cfg.min_distance_cm = 10'd2;
      ranger_cfg.max_distance_cm = 10'd400;
      ranger_cfg.cm_per_us_q16   = 12'd1135;
      kept_count        = 0;
      pings_in_group    = 0;
      ema_value         = '0;
      pings_outstanding = 0;
      send_idle_pct     = 7;
      recv_idle_pct     = 85;
      ping_xfer         = 1'b0;
      idle_cycles       = 0;
      error_count       = 0;
      pings_sent        = 0;
      readings_checked  = 0;
      settings_used     = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edges of the window, timeouts, even and odd kept counts, default setting
      @(posedge clock);
      foreach (directed_echoes[i]) queue_echo(directed_echoes[i]);
      wait_idle();

      program_ranger(511, 0, 1023, 4095);   // alpha saturates, widest window
      run_batch(120, 7, 85);
      program_ranger(0, 1023, 0, 2000);     // min above max: every group reports no_valid
      run_batch(40, 7, 85);
      program_ranger(256, 0, 0, 0);         // zero median drops the filter back to unloaded
      run_batch(40, 7, 85);
      program_ranger(51, 2, 400, 1135);
      run_batch(100, 85, 7);

      for (int k = 0; k < 10; k++) begin
         min_cm = $urandom_range(300);
         max_cm = $urandom_range(1023, min_cm);
         if ($urandom_range(7) == 0) program_ranger($urandom_range(511), max_cm, min_cm,
                                                    $urandom_range(4095));
         else program_ranger($urandom_range(511), min_cm, max_cm, $urandom_range(4095, 1));
         if (k < 4) run_batch(60, 85, 7);
         else run_batch(60, 0, 0);
      end

      $display("%0d pings sent, %0d filtered readings checked across %0d register settings",
               pings_sent, readings_checked, settings_used);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", error_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/edme_pkg.sv
hw/rtl/edme_csr.sv
hw/rtl/echo_distance_median_ema_core.sv
sim/tb_echo_distance_median_ema_core.sv
